// ===== src/pcf_pkg.sv =====
// Shared types and constants of the PCIe configuration access filter.
// No dependencies; the top level, front end, back end and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_LOAD  = 2'd2,
      KIND_NOP   = 2'd3
   } pcf_kind_type;

   typedef enum logic [1:0] {
      CSR_BUS_FIRST = 2'd0,
      CSR_BUS_LAST  = 2'd1,
      CSR_LIST_LEN  = 2'd2
   } pcf_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPLY
   } pcf_state_type;

   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int CODE_W      = 28;
   localparam int INDEX_W     = 12;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         bus_number;
      logic [4:0]         device_number;
      logic [2:0]         function_number;
      logic [11:0]        register_offset;
      logic [2:0]         access_size;
      logic [31:0]        write_value;
      logic [31:0]        current_word;
      logic [INDEX_W-1:0] entry_index;
      logic [CODE_W-1:0]  entry_code;
   } pcf_req_type;

   typedef struct packed {
      logic              accepted;
      logic              target_root_port;
      logic [CODE_W-1:0] access_address;
      logic              write_enable;
      logic [31:0]       write_data;
      logic [31:0]       read_data;
   } pcf_rsp_type;

   // classified word handed from the front to the back
   typedef struct packed {
      pcf_kind_type       kind;
      logic               bus_ok;
      logic               bdf_zero;
      logic               size_ok;
      logic [CODE_W-1:0]  code;
      logic [CODE_W-1:0]  offset;
      logic [2:0]         size;
      logic [31:0]        write_value;
      logic [31:0]        current_word;
      logic [INDEX_W-1:0] entry_index;
      logic [CODE_W-1:0]  entry_code;
   } pcf_cmd_type;

endpackage

`default_nettype wire

// ===== src/pcie_config_access_filter.sv =====
// PCIe configuration access filter, top level: config registers, front end, back end.
// Path: an accepted word passes through the two-entry queue and the command register into
// the response register; a list search first compares up to min(list_len, LIST_DEPTH) entries.
// The back end takes one word at a time from the queue and compares one list entry per cycle
// during a search, set by the single read port of the list memory.
// Reset: bus_first 0, bus_last 255, list_len 0, queue and response empty; list RAM
`timescale 1ns / 1ps
`default_nettype none

module pcie_config_access_filter
   import pcf_pkg::*;
#(
   parameter int LIST_DEPTH = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pcf_req_type            req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pcf_rsp_type                 rsp_word,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // contents are undefined until loaded and are not cleared.
   logic [7:0]            bus_first_ff;
   logic [7:0]            bus_last_ff;
   logic [CSR_DATA_W-1:0] list_len_ff;
   logic                  q_valid;
   logic                  q_pop;
   pcf_cmd_type           q_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_first_ff <= 8'd0;
         bus_last_ff  <= 8'd255;
         list_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BUS_FIRST: bus_first_ff <= csr_wdata[7:0];
            CSR_BUS_LAST:  bus_last_ff  <= csr_wdata[7:0];
            CSR_LIST_LEN:  list_len_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   pcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .bus_first (bus_first_ff),
      .bus_last  (bus_last_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   pcf_back #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .list_len  (list_len_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef NO_ASSERTIONS
   a_we_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.write_enable |-> rsp_word.accepted)
      else $error("write enable on a rejected access");

   a_root_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.target_root_port |->
         rsp_word.accepted && (rsp_word.access_address[27:12] == 16'd0))
      else $error("root port window with nonzero BDF offset");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.accepted |->
         (rsp_word.access_address == '0) && (rsp_word.write_data == 32'd0))
      else $error("rejected access carries address or data");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== src/pcf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcf_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/pcf_front.sv =====
// Front end: accepts request words, classifies them, and queues them for the back end.
// Depends on pcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcf_front
   import pcf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire pcf_req_type req_word,
   input  wire logic [7:0]  bus_first,
   input  wire logic [7:0]  bus_last,
   output logic             q_valid,
   output pcf_cmd_type      q_cmd,
   input  wire logic        q_pop
);

   pcf_cmd_type cmd_in;
   pcf_cmd_type q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   logic [7:0]  bus_rel;

   assign bus_rel = req_word.bus_number - bus_first;

   always_comb begin
      cmd_in.kind         = pcf_kind_type'(req_word.func);
      cmd_in.bus_ok       = (req_word.bus_number >= bus_first) &&
                            (req_word.bus_number <= bus_last);
      cmd_in.bdf_zero     = (req_word.bus_number == 8'd0) &&
                            (req_word.device_number == 5'd0) &&
                            (req_word.function_number == 3'd0);
      cmd_in.size_ok      = (req_word.access_size == SIZE_BYTE) ||
                            (req_word.access_size == SIZE_HALF) ||
                            (req_word.access_size == SIZE_WORD);
      cmd_in.code         = {req_word.bus_number, req_word.device_number,
                             req_word.function_number, 12'd0};
      cmd_in.offset       = {bus_rel, req_word.device_number,
                             req_word.function_number, req_word.register_offset};
      cmd_in.size         = req_word.access_size;
      cmd_in.write_value  = req_word.write_value;
      cmd_in.current_word = req_word.current_word;
      cmd_in.entry_index  = req_word.entry_index;
      cmd_in.entry_code   = req_word.entry_code;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pcf_back.sv =====
// Back end: stores list entries, walks the BDF list, builds and registers the response word.
// Depends on pcf_pkg and pcf_ram.
`timescale 1ns / 1ps
`default_nettype none

module pcf_back
   import pcf_pkg::*;
#(
   parameter int LIST_DEPTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire pcf_cmd_type           q_cmd,
   output logic                       q_pop,
   input  wire logic [CSR_DATA_W-1:0] list_len,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pcf_rsp_type                rsp_word
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);

   pcf_state_type    state_ff, state_in;
   pcf_cmd_type      cmd_ff;
   logic             ok_ff, ok_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    limit_ff;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff;
   pcf_rsp_type      rsp_ff, rsp_in;

   logic [CW-1:0]     lim_now;
   logic              access_now, needs_walk, ok_now, load_ok;
   logic              match, issue, walk_done, out_free;
   logic              ram_we, rd_en, rsp_load;
   logic [CODE_W-1:0] rd_data;

   pcf_ram #(
      .WIDTH (CODE_W),
      .DEPTH (LIST_DEPTH)
   ) u_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_cmd.entry_index[AW-1:0]),
      .wr_data (q_cmd.entry_code),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign lim_now    = (list_len > CSR_DATA_W'(LIST_DEPTH)) ? CW'(LIST_DEPTH)
                                                            : list_len[CW-1:0];
   assign access_now = (q_cmd.kind == KIND_READ) || (q_cmd.kind == KIND_WRITE);
   assign ok_now     = access_now && q_cmd.bus_ok && q_cmd.size_ok && q_cmd.bdf_zero;
   assign needs_walk = access_now && q_cmd.bus_ok && q_cmd.size_ok && !q_cmd.bdf_zero &&
                       (lim_now != '0);
   assign load_ok    = ({1'b0, q_cmd.entry_index} < (INDEX_W + 1)'(LIST_DEPTH));

   assign match     = pend_ff && (rd_data == cmd_ff.code);
   assign issue     = (idx_ff < limit_ff) && !match;
   assign walk_done = match || (!pend_ff && (idx_ff == limit_ff));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = needs_walk ? ST_WALK : ST_REPLY;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      ram_we   = 1'b0;
      rd_en    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop  = q_valid;
            ram_we = q_valid && (q_cmd.kind == KIND_LOAD) && load_ok;
         end
         ST_WALK: begin
            rd_en = issue;
         end
         ST_REPLY: begin
            rsp_load = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      ok_in   = ok_ff;
      idx_in  = idx_ff;
      pend_in = 1'b0;
      if (q_pop) begin
         ok_in  = ok_now;
         idx_in = '0;
      end else if (state_ff == ST_WALK) begin
         pend_in = issue;
         if (issue) begin
            idx_in = idx_ff + 1'b1;
         end
         if (walk_done) begin
            ok_in = match;
         end
      end
   end

   // response word from the classified word and the verdict
   always_comb begin
      logic [4:0]  sh;
      logic [31:0] lanes;
      logic [31:0] mask;
      sh    = {cmd_ff.offset[1:0], 3'b000};
      lanes = cmd_ff.current_word >> sh;
      mask  = (cmd_ff.size == SIZE_BYTE) ? 32'h0000_00ff : 32'h0000_ffff;
      rsp_in = '0;
      case (cmd_ff.kind)
         KIND_READ: begin
            rsp_in.read_data = '1;
            if (ok_ff) begin
               rsp_in.accepted         = 1'b1;
               rsp_in.target_root_port = cmd_ff.bdf_zero;
               rsp_in.access_address   = {cmd_ff.offset[CODE_W-1:2], 2'b00};
               if (cmd_ff.size == SIZE_BYTE) begin
                  rsp_in.read_data = {24'd0, lanes[7:0]};
               end else if (cmd_ff.size == SIZE_HALF) begin
                  rsp_in.read_data = {16'd0, lanes[15:0]};
               end else begin
                  rsp_in.read_data = cmd_ff.current_word;
               end
            end
         end
         KIND_WRITE: begin
            if (ok_ff) begin
               rsp_in.accepted         = 1'b1;
               rsp_in.target_root_port = cmd_ff.bdf_zero;
               rsp_in.write_enable     = 1'b1;
               if (cmd_ff.size == SIZE_WORD) begin
                  rsp_in.access_address = cmd_ff.offset;
                  rsp_in.write_data     = cmd_ff.write_value;
               end else begin
                  rsp_in.access_address = {cmd_ff.offset[CODE_W-1:2], 2'b00};
                  rsp_in.write_data     = (cmd_ff.current_word & ~(mask << sh)) |
                                          ((cmd_ff.write_value & mask) << sh);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff  <= ok_in;
      idx_ff <= idx_in;
      if (q_pop) begin
         cmd_ff   <= q_cmd;
         limit_ff <= lim_now;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for pcie_config_access_filter: directed and random words are checked
// against a predictor of the filter. Depends on pcf_pkg and the filter top level.
`timescale 1ns / 1ps

module tb;
   import pcf_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pcf_req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pcf_rsp_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [CODE_W-1:0] bdf_store [0:LIST_DEPTH-1];
   logic [7:0] win_first = 8'd0;
   logic [7:0] win_last = 8'd255;
   logic [CSR_DATA_W-1:0] list_count = '0;
   pcf_rsp_type due_rsp [$];
   int error_count = 0;
   int quiet_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   pcie_config_access_filter #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic pcf_rsp_type filter_predict(input pcf_req_type w);
      pcf_rsp_type r;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] off;
      logic [7:0] bus_rel;
      logic [31:0] lane_mask;
      int unsigned walk_len;
      int unsigned shift;
      logic listed;
      logic size_ok;
      r = '0;
      if (w.func == KIND_LOAD) begin
         if (w.entry_index < LIST_DEPTH) bdf_store[w.entry_index] = w.entry_code;
      end else if (w.func == KIND_READ || w.func == KIND_WRITE) begin
         code = {w.bus_number, w.device_number, w.function_number, 12'h000};
         walk_len = (list_count > LIST_DEPTH) ? LIST_DEPTH : list_count;
         listed = (code == '0);
         for (int i = 0; i < walk_len; i++)
            if (bdf_store[i] == code) listed = 1'b1;
         size_ok = (w.access_size == SIZE_BYTE) || (w.access_size == SIZE_HALF) ||
                   (w.access_size == SIZE_WORD);
         if (w.func == KIND_READ) r.read_data = '1;
         if (w.bus_number >= win_first && w.bus_number <= win_last && listed && size_ok) begin
            bus_rel = w.bus_number - win_first;
            off = {bus_rel, w.device_number, w.function_number, w.register_offset};
            shift = {off[1:0], 3'b000};
            r.accepted = 1'b1;
            r.target_root_port = (code == '0);
            if (w.func == KIND_READ) begin
               r.access_address = {off[CODE_W-1:2], 2'b00};
               if (w.access_size == SIZE_BYTE)
                  r.read_data = (w.current_word >> shift) & 32'h0000_00FF;
               else if (w.access_size == SIZE_HALF)
                  r.read_data = (w.current_word >> shift) & 32'h0000_FFFF;
               else
                  r.read_data = w.current_word;
            end else begin
               r.write_enable = 1'b1;
               if (w.access_size == SIZE_WORD) begin
                  r.access_address = off;
                  r.write_data = w.write_value;
               end else begin
                  lane_mask = (w.access_size == SIZE_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF;
                  r.access_address = {off[CODE_W-1:2], 2'b00};
                  r.write_data = (w.current_word & ~(lane_mask << shift)) |
                                 ((w.write_value & lane_mask) << shift);
               end
            end
         end
      end
      return r;
   endfunction

   function automatic logic [CODE_W-1:0] noise_code();
      logic [CODE_W-1:0] code;
      code = CODE_W'($urandom);
      if (code[CODE_W-1:12] == 16'hFFFF) code[11:0] = '0;
      return code;
   endfunction

   function automatic logic [CODE_W-1:0] listed_code();
      logic [7:0] bus;
      bus = 8'($urandom);
      if (win_first <= win_last && $urandom_range(0, 99) < 85)
         bus = 8'($urandom_range(win_first, win_last));
      return {bus, 5'($urandom), 3'($urandom), 12'h000};
   endfunction

   function automatic pcf_req_type random_word();
      pcf_req_type w;
      w.func = 2'($urandom);
      w.bus_number = 8'($urandom);
      w.device_number = 5'($urandom);
      w.function_number = 3'($urandom);
      w.register_offset = 12'($urandom);
      w.access_size = 3'($urandom);
      w.write_value = $urandom;
      w.current_word = $urandom;
      w.entry_index = INDEX_W'($urandom);
      w.entry_code = noise_code();
      return w;
   endfunction

   function automatic pcf_req_type access_word(input pcf_kind_type kind, input logic [7:0] bus,
         input logic [4:0] dev, input logic [2:0] fn, input logic [11:0] offset,
         input logic [2:0] size, input logic [31:0] wval, input logic [31:0] word);
      pcf_req_type w;
      w = random_word();
      w.func = kind;
      w.bus_number = bus;
      w.device_number = dev;
      w.function_number = fn;
      w.register_offset = offset;
      w.access_size = size;
      w.write_value = wval;
      w.current_word = word;
      return w;
   endfunction

   function automatic pcf_req_type load_word(input logic [INDEX_W-1:0] index,
         input logic [CODE_W-1:0] code);
      pcf_req_type w;
      w = random_word();
      w.func = KIND_LOAD;
      w.entry_index = index;
      w.entry_code = code;
      return w;
   endfunction

   function automatic pcf_req_type random_item();
      pcf_req_type w;
      logic [CODE_W-1:0] code;
      int unsigned pick;
      int unsigned walk_len;
      w = random_word();
      walk_len = (list_count > LIST_DEPTH) ? LIST_DEPTH : list_count;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         w.func = KIND_LOAD;
         if (walk_len != 0 && $urandom_range(0, 1) == 1)
            w.entry_index = INDEX_W'($urandom_range(0, walk_len - 1));
         if ($urandom_range(0, 99) < 80) w.entry_code = listed_code();
      end else if (pick < 15) begin
         w.func = KIND_NOP;
      end else begin
         w.func = ($urandom_range(0, 1) == 1) ? KIND_WRITE : KIND_READ;
         code = {w.bus_number, w.device_number, w.function_number, 12'h000};
         pick = $urandom_range(0, 99);
         if (pick < 55 && walk_len != 0) code = bdf_store[$urandom_range(0, walk_len - 1)];
         else if (pick < 70) code = '0;
         {w.bus_number, w.device_number, w.function_number} = code[CODE_W-1:12];
         if ($urandom_range(0, 99) < 80) begin
            pick = $urandom_range(0, 2);
            w.access_size = (pick == 0) ? SIZE_BYTE : (pick == 1) ? SIZE_HALF : SIZE_WORD;
         end
      end
      return w;
   endfunction

   task automatic send_word(input pcf_req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      due_rsp.push_back(filter_predict(w));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_rsp.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
         input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_BUS_FIRST) win_first = data[7:0];
      else if (index == CSR_BUS_LAST) win_last = data[7:0];
      else if (index == CSR_LIST_LEN) list_count = data;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
         input logic [31:0] got);
      if (error_count < 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
      error_count++;
   endtask

   task automatic test_lanes_and_sizes();
      pcf_req_type w;
      send_word(access_word(KIND_READ, 8'h00, 5'h00, 3'h0, 12'h000, SIZE_WORD,
                            32'h0000_0000, 32'hFFFF_FFFF));
      send_word(access_word(KIND_READ, 8'h00, 5'h00, 3'h0, 12'hFFF, SIZE_BYTE,
                            32'hFFFF_FFFF, 32'h8765_4321));
      send_word(access_word(KIND_READ, 8'h00, 5'h00, 3'h0, 12'h003, SIZE_HALF,
                            32'h0000_0000, 32'hA5C3_0F96));
      send_word(access_word(KIND_READ, 8'h00, 5'h00, 3'h0, 12'h101, SIZE_HALF,
                            32'h0000_0000, 32'h0000_0000));
      send_word(access_word(KIND_WRITE, 8'h00, 5'h00, 3'h0, 12'hFFD, SIZE_BYTE,
                            32'h1234_56AB, 32'h0000_0000));
      send_word(access_word(KIND_WRITE, 8'h00, 5'h00, 3'h0, 12'h003, SIZE_HALF,
                            32'hFFFF_BEEF, 32'h0000_0000));
      send_word(access_word(KIND_WRITE, 8'h00, 5'h00, 3'h0, 12'h002, SIZE_HALF,
                            32'h0000_0000, 32'hFFFF_FFFF));
      send_word(access_word(KIND_WRITE, 8'h00, 5'h00, 3'h0, 12'h7FE, SIZE_WORD,
                            32'hFFFF_FFFF, 32'h0000_0000));
      for (int s = 0; s < 8; s++)
         if (s != 1 && s != 2 && s != 4)
            send_word(access_word((s % 2 == 1) ? KIND_WRITE : KIND_READ, 8'h00, 5'h00, 3'h0,
                                  12'h004, 3'(s), 32'hFFFF_FFFF, 32'h1357_9BDF));
      send_word(access_word(KIND_READ, 8'hFF, 5'h1F, 3'h7, 12'hFFF, SIZE_WORD,
                            32'h0000_0000, 32'h0000_0000));
      send_word(access_word(KIND_WRITE, 8'h01, 5'h00, 3'h1, 12'h000, SIZE_BYTE,
                            32'h0000_00FF, 32'hFFFF_FFFF));
      w = random_word();
      w.func = KIND_NOP;
      send_word(w);
      send_word(load_word(12'd0, {8'hFF, 5'h1F, 3'h7, 12'h000}));
      send_word(load_word(12'd1, {8'h01, 5'h00, 3'h1, 12'h000}));
      wait_idle();
   endtask

   task automatic test_bus_window();
      csr_write(CSR_LIST_LEN, 13'd2);
      csr_write(CSR_BUS_FIRST, 13'h1F01);
      csr_write(CSR_BUS_LAST, 13'h1EFF);
      send_word(access_word(KIND_READ, 8'hFF, 5'h1F, 3'h7, 12'hFFC, SIZE_WORD,
                            32'h0000_0000, 32'hDEAD_BEEF));
      send_word(access_word(KIND_WRITE, 8'h01, 5'h00, 3'h1, 12'h102, SIZE_HALF,
                            32'h0000_CAFE, 32'h1111_2222));
      send_word(access_word(KIND_READ, 8'h00, 5'h00, 3'h0, 12'h000, SIZE_WORD,
                            32'h0000_0000, 32'h0000_0000));
      send_word(access_word(KIND_READ, 8'h02, 5'h00, 3'h1, 12'h010, SIZE_BYTE,
                            32'h0000_0000, 32'h5A5A_5A5A));
      send_word(access_word(KIND_READ, 8'h01, 5'h00, 3'h0, 12'h010, SIZE_BYTE,
                            32'h0000_0000, 32'h5A5A_5A5A));
      wait_idle();
      csr_write(CSR_SPARE, 13'h1FFF);
      csr_write(CSR_BUS_FIRST, 13'd200);
      csr_write(CSR_BUS_LAST, 13'd100);
      send_word(access_word(KIND_READ, 8'hFF, 5'h1F, 3'h7, 12'h000, SIZE_WORD,
                            32'h0000_0000, 32'h0F0F_0F0F));
      send_word(access_word(KIND_WRITE, 8'd150, 5'h00, 3'h0, 12'h000, SIZE_WORD,
                            32'hFFFF_FFFF, 32'h0000_0000));
      wait_idle();
      csr_write(CSR_BUS_FIRST, 13'd255);
      csr_write(CSR_BUS_LAST, 13'd255);
      send_word(access_word(KIND_READ, 8'hFF, 5'h1F, 3'h7, 12'h3FF, SIZE_BYTE,
                            32'h0000_0000, 32'hC0DE_F00D));
      send_word(access_word(KIND_READ, 8'hFE, 5'h1F, 3'h7, 12'h000, SIZE_WORD,
                            32'h0000_0000, 32'hC0DE_F00D));
      wait_idle();
   endtask

   task automatic test_random_traffic(input logic [7:0] first, input logic [7:0] last,
         input int unsigned count, input int unsigned items);
      csr_write(CSR_BUS_FIRST, {5'($urandom), first});
      csr_write(CSR_BUS_LAST, {5'($urandom), last});
      csr_write(CSR_LIST_LEN, CSR_DATA_W'(count));
      for (int i = 0; i < count; i++) send_word(load_word(INDEX_W'(i), listed_code()));
      for (int i = 0; i < items; i++) send_word(random_item());
      wait_idle();
   endtask

   task automatic test_full_list();
      pcf_req_type w;
      csr_write(CSR_BUS_FIRST, 13'd0);
      csr_write(CSR_BUS_LAST, 13'd255);
      csr_write(CSR_LIST_LEN, 13'h1000);
      for (int i = 0; i < LIST_DEPTH - 1; i++) send_word(load_word(INDEX_W'(i), listed_code()));
      send_word(load_word(INDEX_W'(LIST_DEPTH - 1), {8'hFE, 5'h1E, 3'h5, 12'h000}));
      send_word(access_word(KIND_READ, 8'hFE, 5'h1E, 3'h5, 12'h3FE, SIZE_HALF,
                            32'h0000_0000, 32'h89AB_CDEF));
      send_word(access_word(KIND_WRITE, 8'hFE, 5'h1E, 3'h5, 12'h001, SIZE_BYTE,
                            32'h0000_0042, 32'h89AB_CDEF));
      w = random_word();
      w.func = KIND_READ;
      w.access_size = SIZE_WORD;
      send_word(w);
      send_word(access_word(KIND_READ, 8'h00, 5'h00, 3'h0, 12'h008, SIZE_WORD,
                            32'h0000_0000, 32'h7654_3210));
      wait_idle();
      csr_write(CSR_LIST_LEN, 13'h1FFF);
      send_word(access_word(KIND_READ, 8'hFE, 5'h1E, 3'h5, 12'h000, SIZE_WORD,
                            32'h0000_0000, 32'h2468_ACE0));
      w = random_word();
      w.func = KIND_WRITE;
      w.access_size = SIZE_WORD;
      send_word(w);
      wait_idle();
      csr_write(CSR_LIST_LEN, CSR_DATA_W'(LIST_DEPTH - 1));
      send_word(access_word(KIND_READ, 8'hFE, 5'h1E, 3'h5, 12'h000, SIZE_WORD,
                            32'h0000_0000, 32'h2468_ACE0));
      wait_idle();
      csr_write(CSR_LIST_LEN, 13'd0);
      send_word(access_word(KIND_WRITE, 8'hFE, 5'h1E, 3'h5, 12'h000, SIZE_WORD,
                            32'hFFFF_FFFF, 32'h0000_0000));
      send_word(access_word(KIND_READ, 8'h00, 5'h00, 3'h0, 12'hFFE, SIZE_HALF,
                            32'h0000_0000, 32'hFFFF_0000));
      wait_idle();
   endtask

   always @(posedge clock) begin
      pcf_rsp_type want;
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp.size() == 0) begin
            note_mismatch("unexpected word", 32'd0, 32'(rsp_word.access_address));
         end else begin
            want = due_rsp.pop_front();
            if (rsp_word.accepted !== want.accepted)
               note_mismatch("accepted", 32'(want.accepted), 32'(rsp_word.accepted));
            if (rsp_word.target_root_port !== want.target_root_port)
               note_mismatch("target_root_port", 32'(want.target_root_port),
                             32'(rsp_word.target_root_port));
            if (rsp_word.access_address !== want.access_address)
               note_mismatch("access_address", 32'(want.access_address),
                             32'(rsp_word.access_address));
            if (rsp_word.write_enable !== want.write_enable)
               note_mismatch("write_enable", 32'(want.write_enable),
                             32'(rsp_word.write_enable));
            if (rsp_word.write_data !== want.write_data)
               note_mismatch("write_data", want.write_data, rsp_word.write_data);
            if (rsp_word.read_data !== want.read_data)
               note_mismatch("read_data", want.read_data, rsp_word.read_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 23;
      recv_idle_pct = 71;
      test_lanes_and_sizes();
      test_bus_window();
      test_random_traffic(8'd0, 8'd255, 12, 20);
      send_idle_pct = 71;
      recv_idle_pct = 23;
      begin
         logic [7:0] first;
         first = 8'($urandom_range(1, 128));
         test_random_traffic(first, 8'($urandom_range(first, 255)), $urandom_range(1, 24), 20);
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
      begin
         logic [7:0] only_bus;
         only_bus = 8'($urandom);
         test_random_traffic(only_bus, only_bus, 6, 20);
      end
      test_full_list();
      wait_idle();
      repeat (LIST_DEPTH + 16) @(posedge clock);
      if (error_count == 0 && due_rsp.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
